FILE: rtl/core/srsw_pkg.sv
package srsw_pkg;

  // Width of the payload ports; the window stores PAYLOAD_BITS of it.
  localparam int unsigned PORT_PAYLOAD_W = 64;

  typedef enum logic [1:0] {
    REQ_SEND    = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } timer_op_t;

  typedef enum logic [1:0] {
    ACK_NONE    = 2'd0,
    ACK_BASE    = 2'd1,
    ACK_INSIDE  = 2'd2,
    ACK_OUTSIDE = 2'd3
  } ack_kind_t;

endpackage

FILE: rtl/core/selective_repeat_sender_window_top.sv
// Selective-repeat ARQ sender window. Raise start with a request while busy is
// low; the block answers every request with exactly one result, shown for one
// cycle with out_valid high, and the receiver cannot stall it. A request is
// answered in registered steps: look up the window offset, form the ring index,
// act, report. Busy stays high through the report cycle, so the next request is
// taken only after the report. An acknowledgement of the oldest packet goes
// through a slide that clears one slot per cycle before the report.
// Packets live in a ring of SEQ_SPACE/2 slots; the slot of a sequence number
// is found from its distance to base, never by searching.
module selective_repeat_sender_window_top #(
  parameter int unsigned SEQ_SPACE    = 8,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_req_type,
  input  logic [srsw_pkg::PORT_PAYLOAD_W-1:0]  in_payload,
  input  logic [$clog2(SEQ_SPACE)-1:0]         in_seq_num,
  input  logic                                 in_ack_intact,
  output logic                                 out_valid,
  output logic                                 out_accepted,
  output logic                                 out_tx_valid,
  output logic [$clog2(SEQ_SPACE)-1:0]         out_tx_seq,
  output logic [srsw_pkg::PORT_PAYLOAD_W-1:0]  out_tx_payload,
  output logic [1:0]                           out_timer_op,
  output logic [$clog2(SEQ_SPACE)-1:0]         out_timer_seq,
  output logic [1:0]                           out_ack_kind,
  output logic                                 out_window_full,
  output logic [$clog2(SEQ_SPACE)-1:0]         out_base_seq
);
  import srsw_pkg::*;

  localparam int unsigned SEQ_W = $clog2(SEQ_SPACE);
  localparam int unsigned HALF  = SEQ_SPACE / 2;
  localparam int unsigned IDX_W = $clog2(HALF);
  localparam int unsigned CNT_W = $clog2(HALF + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIND  = 5'b00010,
    S_INDEX = 5'b00100,
    S_EXEC  = 5'b01000,
    S_SLIDE = 5'b10000
  } state_t;

  // Report state is folded in as a separate flag so the strobe is one register.
  state_t                  state_r, state_nxt;
  logic                    report_r, report_nxt;

  req_type_t               req_r;
  logic [PAYLOAD_BITS-1:0] req_pay_r;
  logic [SEQ_W-1:0]        req_seq_r;
  logic                    req_intact_r;

  logic [CNT_W-1:0]        outstanding_r, outstanding_nxt;
  logic [SEQ_W-1:0]        next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]        base_r, base_nxt;
  logic                    waiting_r, waiting_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [HALF-1:0]         acked_r, acked_nxt;

  logic [CNT_W-1:0]        off_r, off_nxt;
  logic                    hit_r, hit_nxt;
  logic [IDX_W-1:0]        phys_r, phys_nxt;

  logic                    acc_r, acc_nxt;
  logic                    txv_r, txv_nxt;
  logic [SEQ_W-1:0]        txs_r, txs_nxt;
  logic [PAYLOAD_BITS-1:0] txp_r, txp_nxt;
  logic                    from_mem_r, from_mem_nxt;
  timer_op_t               top_r, top_nxt;
  logic [SEQ_W-1:0]        tseq_r, tseq_nxt;
  ack_kind_t               kind_r, kind_nxt;

  logic [PAYLOAD_BITS-1:0] mem [HALF];
  logic [PAYLOAD_BITS-1:0] rd_data_r;
  logic                    mem_we;

  // Shared ring arithmetic: one add and one wrap compare per step.
  logic [SEQ_W:0]          seq_dist;
  logic [IDX_W:0]          ring_sum;
  logic [IDX_W-1:0]        ring_idx;

  always_comb begin
    seq_dist = {1'b0, req_seq_r} - {1'b0, base_r};
    if (req_seq_r < base_r) begin
      seq_dist = seq_dist + (SEQ_W + 1)'(SEQ_SPACE);
    end
    ring_sum = state_r == S_SLIDE ? {1'b0, head_r} + (IDX_W + 1)'(1)
                                  : {1'b0, head_r} + {1'b0, off_r[IDX_W-1:0]};
    ring_idx = ring_sum >= (IDX_W + 1)'(HALF) ? IDX_W'(ring_sum - (IDX_W + 1)'(HALF))
                                              : ring_sum[IDX_W-1:0];
  end

  always_comb begin
    state_nxt       = state_r;
    report_nxt      = 1'b0;
    outstanding_nxt = outstanding_r;
    next_seq_nxt    = next_seq_r;
    base_nxt        = base_r;
    waiting_nxt     = waiting_r;
    head_nxt        = head_r;
    acked_nxt       = acked_r;
    off_nxt         = off_r;
    hit_nxt         = hit_r;
    phys_nxt        = phys_r;
    acc_nxt         = acc_r;
    txv_nxt         = txv_r;
    txs_nxt         = txs_r;
    txp_nxt         = txp_r;
    from_mem_nxt    = from_mem_r;
    top_nxt         = top_r;
    tseq_nxt        = tseq_r;
    kind_nxt        = kind_r;
    mem_we          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // Hold off a new request while the report is still on the ports.
        if (start && !report_r) begin
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        // A send goes to the first free slot; otherwise locate by distance.
        hit_nxt = seq_dist < (SEQ_W + 1)'(outstanding_r);
        off_nxt = req_r == REQ_SEND ? outstanding_r : CNT_W'(seq_dist);
        state_nxt = S_INDEX;
      end
      S_INDEX: begin
        phys_nxt  = ring_idx;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        acc_nxt      = 1'b0;
        txv_nxt      = 1'b0;
        txs_nxt      = '0;
        txp_nxt      = '0;
        from_mem_nxt = 1'b0;
        top_nxt      = TMR_NONE;
        tseq_nxt     = '0;
        kind_nxt     = ACK_NONE;
        state_nxt    = S_IDLE;
        report_nxt   = 1'b1;
        unique case (req_r)
          REQ_SEND: begin
            if (outstanding_r < CNT_W'(HALF)) begin
              mem_we            = 1'b1;
              acked_nxt[phys_r] = 1'b0;
              acc_nxt           = 1'b1;
              txv_nxt           = 1'b1;
              txs_nxt           = next_seq_r;
              txp_nxt           = req_pay_r;
              top_nxt           = TMR_START;
              tseq_nxt          = next_seq_r;
              outstanding_nxt   = outstanding_r + CNT_W'(1);
              next_seq_nxt      = next_seq_r == SEQ_W'(SEQ_SPACE - 1) ? '0
                                                                      : next_seq_r + SEQ_W'(1);
              waiting_nxt       = outstanding_r == CNT_W'(HALF - 1);
            end else begin
              waiting_nxt = 1'b1;
            end
          end
          REQ_ACK: begin
            if (req_intact_r) begin
              top_nxt  = TMR_STOP;
              tseq_nxt = req_seq_r;
              if (hit_r) begin
                acked_nxt[phys_r] = 1'b1;
                if (off_r == '0) begin
                  kind_nxt    = ACK_BASE;
                  waiting_nxt = 1'b0;
                  report_nxt  = 1'b0;
                  state_nxt   = S_SLIDE;
                end else begin
                  kind_nxt = ACK_INSIDE;
                end
              end else begin
                kind_nxt = ACK_OUTSIDE;
              end
            end
          end
          REQ_TIMEOUT: begin
            if (outstanding_r != '0 && hit_r) begin
              txv_nxt      = 1'b1;
              txs_nxt      = req_seq_r;
              from_mem_nxt = 1'b1;
              top_nxt      = TMR_RESTART;
              tseq_nxt     = req_seq_r;
            end
          end
          default: begin
          end
        endcase
      end
      S_SLIDE: begin
        // Drop one marked slot from the head per cycle.
        if (outstanding_r != '0 && acked_r[head_r]) begin
          acked_nxt[head_r] = 1'b0;
          head_nxt          = ring_idx;
          base_nxt          = base_r == SEQ_W'(SEQ_SPACE - 1) ? '0 : base_r + SEQ_W'(1);
          outstanding_nxt   = outstanding_r - CNT_W'(1);
        end else begin
          state_nxt  = S_IDLE;
          report_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      report_r      <= 1'b0;
      outstanding_r <= '0;
      next_seq_r    <= '0;
      base_r        <= '0;
      waiting_r     <= 1'b0;
      head_r        <= '0;
      acked_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      report_r      <= report_nxt;
      outstanding_r <= outstanding_nxt;
      next_seq_r    <= next_seq_nxt;
      base_r        <= base_nxt;
      waiting_r     <= waiting_nxt;
      head_r        <= head_nxt;
      acked_r       <= acked_nxt;
    end
  end

  // Request capture and working/result payload registers.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r        <= req_type_t'(in_req_type);
      req_pay_r    <= in_payload[PAYLOAD_BITS-1:0];
      req_seq_r    <= in_seq_num;
      req_intact_r <= in_ack_intact;
    end
    off_r      <= off_nxt;
    hit_r      <= hit_nxt;
    phys_r     <= phys_nxt;
    acc_r      <= acc_nxt;
    txv_r      <= txv_nxt;
    txs_r      <= txs_nxt;
    txp_r      <= txp_nxt;
    from_mem_r <= from_mem_nxt;
    top_r      <= top_nxt;
    tseq_r     <= tseq_nxt;
    kind_r     <= kind_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[phys_r] <= req_pay_r;
    end
    rd_data_r <= mem[phys_r];
  end

  assign busy            = state_r != S_IDLE || report_r;
  assign out_valid       = report_r;
  assign out_accepted    = acc_r;
  assign out_tx_valid    = txv_r;
  assign out_tx_seq      = txs_r;
  assign out_tx_payload  = PORT_PAYLOAD_W'(from_mem_r ? rd_data_r : txp_r);
  assign out_timer_op    = top_r;
  assign out_timer_seq   = tseq_r;
  assign out_ack_kind    = kind_r;
  assign out_window_full = waiting_r;
  assign out_base_seq    = base_r;

endmodule

FILE: rtl/core/srsw_checker.sv
module srsw_checker #(
  parameter int unsigned SEQ_SPACE = 8
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 out_valid,
  input logic                                 out_accepted,
  input logic                                 out_tx_valid,
  input logic [$clog2(SEQ_SPACE)-1:0]         out_tx_seq,
  input logic [1:0]                           out_timer_op,
  input logic [$clog2(SEQ_SPACE)-1:0]         out_timer_seq,
  input logic [1:0]                           out_ack_kind
);
  import srsw_pkg::*;

  // Each request yields one report, and the block stays busy until then.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy && !$past(out_valid))
    else $error("report outside a busy request");

  a_accept_starts_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |->
      out_tx_valid && out_timer_op == TMR_START && out_timer_seq == out_tx_seq)
    else $error("accepted send without transmit and timer start");

  a_ack_stops_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_kind != ACK_NONE |->
      !out_tx_valid && out_timer_op == TMR_STOP)
    else $error("acknowledgement without timer stop");

  a_restart_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timer_op == TMR_RESTART |->
      out_tx_valid && !out_accepted && out_tx_seq == out_timer_seq)
    else $error("restart without matching retransmit");

endmodule

bind selective_repeat_sender_window_top srsw_checker #(.SEQ_SPACE(SEQ_SPACE)) u_srsw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_accepted  (out_accepted),
  .out_tx_valid  (out_tx_valid),
  .out_tx_seq    (out_tx_seq),
  .out_timer_op  (out_timer_op),
  .out_timer_seq (out_timer_seq),
  .out_ack_kind  (out_ack_kind)
);

FILE: sim/tb_selective_repeat_sender_window_top.sv
`timescale 1ns / 100ps

module tb_selective_repeat_sender_window_top;
  import srsw_pkg::*;

  localparam int unsigned SEQ_SPACE   = 8;
  localparam int unsigned HALF        = SEQ_SPACE / 2;
  localparam int unsigned SEQ_W       = $clog2(SEQ_SPACE);
  localparam int unsigned PAY_W       = PORT_PAYLOAD_W;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          TAIL_CYCLES = 20;

  typedef struct packed {
    logic              accepted;
    logic              tx_valid;
    logic [SEQ_W-1:0]  tx_seq;
    logic [PAY_W-1:0]  tx_payload;
    logic [1:0]        timer_op;
    logic [SEQ_W-1:0]  timer_seq;
    logic [1:0]        ack_kind;
    logic              window_full;
    logic [SEQ_W-1:0]  base_seq;
  } window_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0]       in_req_type;
  logic [PAY_W-1:0] in_payload;
  logic [SEQ_W-1:0] in_seq_num;
  logic             in_ack_intact;
  logic             out_valid;
  logic             out_accepted;
  logic             out_tx_valid;
  logic [SEQ_W-1:0] out_tx_seq;
  logic [PAY_W-1:0] out_tx_payload;
  logic [1:0]       out_timer_op;
  logic [SEQ_W-1:0] out_timer_seq;
  logic [1:0]       out_ack_kind;
  logic             out_window_full;
  logic [SEQ_W-1:0] out_base_seq;

  // Shadow of the sender window
  logic [SEQ_W-1:0] win_seq   [HALF];
  logic [PAY_W-1:0] win_pay   [HALF];
  logic             win_acked [HALF];
  int               win_count;
  logic [SEQ_W-1:0] win_next;
  logic [SEQ_W-1:0] win_base;
  logic             win_full;

  window_result_t pending_results[$];

  int  errors;
  int  cycle_count;
  int  n_checked;
  int  n_sends;
  int  n_refused;
  int  n_acks;
  int  n_timeouts;
  int  n_slides;
  bit  no_idle;

  selective_repeat_sender_window_top #(
    .SEQ_SPACE    (SEQ_SPACE),
    .PAYLOAD_BITS (PAY_W)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_payload      (in_payload),
    .in_seq_num      (in_seq_num),
    .in_ack_intact   (in_ack_intact),
    .out_valid       (out_valid),
    .out_accepted    (out_accepted),
    .out_tx_valid    (out_tx_valid),
    .out_tx_seq      (out_tx_seq),
    .out_tx_payload  (out_tx_payload),
    .out_timer_op    (out_timer_op),
    .out_timer_seq   (out_timer_seq),
    .out_ack_kind    (out_ack_kind),
    .out_window_full (out_window_full),
    .out_base_seq    (out_base_seq)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles at %0t", cycle_count, $time);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int find_window_slot(logic [SEQ_W-1:0] sq);
    for (int i = 0; i < win_count; i++)
      if (win_seq[i] == sq)
        return i;
    return HALF;
  endfunction

  function automatic window_result_t predict_window(logic [1:0] rt, logic [PAY_W-1:0] pay,
                                                    logic [SEQ_W-1:0] sq, logic intact);
    window_result_t r;
    int pos;
    int run;
    r = '0;
    case (rt)
      REQ_SEND: begin
        if (win_count < HALF) begin
          if (win_count == 0)
            for (int i = 0; i < HALF; i++) win_acked[i] = 1'b0;
          win_seq[win_count]   = win_next;
          win_pay[win_count]   = pay;
          win_acked[win_count] = 1'b0;
          r.accepted   = 1'b1;
          r.tx_valid   = 1'b1;
          r.tx_seq     = win_next;
          r.tx_payload = pay;
          r.timer_op   = TMR_START;
          r.timer_seq  = win_next;
          win_count++;
          win_next = win_next + 1'b1;
          win_full = (win_count == HALF);
        end else begin
          win_full = 1'b1;
        end
      end
      REQ_ACK: begin
        if (intact) begin
          pos = find_window_slot(sq);
          r.timer_op  = TMR_STOP;
          r.timer_seq = sq;
          if (pos < HALF) begin
            win_acked[pos] = 1'b1;
            if (win_acked[0]) begin
              // slide past the leading run of acknowledged slots
              run = 0;
              while (run < win_count && win_acked[run]) run++;
              for (int i = 0; i + run < win_count; i++) begin
                win_seq[i]   = win_seq[i + run];
                win_pay[i]   = win_pay[i + run];
                win_acked[i] = win_acked[i + run];
              end
              for (int i = win_count - run; i < HALF; i++) win_acked[i] = 1'b0;
              win_count -= run;
              win_base = win_base + SEQ_W'(run);
              win_full = 1'b0;
              r.ack_kind = ACK_BASE;
              n_slides++;
            end else begin
              r.ack_kind = ACK_INSIDE;
            end
          end else begin
            r.ack_kind = ACK_OUTSIDE;
          end
        end
      end
      REQ_TIMEOUT: begin
        pos = find_window_slot(sq);
        if (win_count != 0 && pos < HALF) begin
          r.tx_valid   = 1'b1;
          r.tx_seq     = win_seq[pos];
          r.tx_payload = win_pay[pos];
          r.timer_op   = TMR_RESTART;
          r.timer_seq  = sq;
        end
      end
      default: ;
    endcase
    r.window_full = win_full;
    r.base_seq    = win_base;
    return r;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_req(input logic [1:0] rt, input logic [PAY_W-1:0] pay,
                          input logic [SEQ_W-1:0] sq, input logic intact);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= rt;
    in_payload    <= pay;
    in_seq_num    <= sq;
    in_ack_intact <= intact;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (rt == REQ_SEND && win_count == HALF) n_refused++;
    case (rt)
      REQ_SEND:    n_sends++;
      REQ_ACK:     n_acks++;
      REQ_TIMEOUT: n_timeouts++;
      default: ;
    endcase
    pending_results.push_back(predict_window(rt, pay, sq, intact));
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [PAY_W-1:0] exp_v,
                             input logic [PAY_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    window_result_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got base_seq %0h", $time,
                 out_base_seq);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("accepted",    PAY_W'(exp_r.accepted),    PAY_W'(out_accepted));
        check_field("tx_valid",    PAY_W'(exp_r.tx_valid),    PAY_W'(out_tx_valid));
        check_field("tx_seq",      PAY_W'(exp_r.tx_seq),      PAY_W'(out_tx_seq));
        check_field("tx_payload",  exp_r.tx_payload,          out_tx_payload);
        check_field("timer_op",    PAY_W'(exp_r.timer_op),    PAY_W'(out_timer_op));
        check_field("timer_seq",   PAY_W'(exp_r.timer_seq),   PAY_W'(out_timer_seq));
        check_field("ack_kind",    PAY_W'(exp_r.ack_kind),    PAY_W'(out_ack_kind));
        check_field("window_full", PAY_W'(exp_r.window_full), PAY_W'(out_window_full));
        check_field("base_seq",    PAY_W'(exp_r.base_seq),    PAY_W'(out_base_seq));
        n_checked++;
      end
    end
  end

  task automatic test_send_extremes();
    send_req(REQ_SEND, '1, 3'd7, 1'b1);
    send_req(REQ_SEND, '0, 3'd0, 1'b0);
  endtask

  task automatic test_full_window();
    send_req(REQ_SEND, 64'h5a5a_a5a5_0f0f_f0f0, 3'd1, 1'b0);
    send_req(REQ_SEND, 64'h8000_0000_0000_0001, 3'd2, 1'b1);
    // window holds four now: refuse the next one
    send_req(REQ_SEND, 64'hdead_beef_cafe_f00d, 3'd3, 1'b1);
  endtask

  task automatic test_ack_cases();
    send_req(REQ_ACK, '0, 3'd0, 1'b0);
    send_req(REQ_ACK, '0, 3'd7, 1'b1);
    send_req(REQ_ACK, '0, 3'd2, 1'b1);
    send_req(REQ_ACK, '1, 3'd2, 1'b1);
    send_req(REQ_ACK, '0, 3'd1, 1'b1);
    // base acked: slide past three
    send_req(REQ_ACK, '0, 3'd0, 1'b1);
  endtask

  task automatic test_timeouts();
    send_req(REQ_TIMEOUT, '0, 3'd3, 1'b0);
    send_req(REQ_TIMEOUT, '0, 3'd5, 1'b1);
    send_req(REQ_ACK, '0, 3'd3, 1'b1);
    send_req(REQ_TIMEOUT, '1, 3'd4, 1'b1);
    send_req(REQ_SEND, 64'h0123_4567_89ab_cdef, 3'd0, 1'b0);
    send_req(REQ_SEND, 64'hfedc_ba98_7654_3210, 3'd0, 1'b0);
    send_req(REQ_ACK, '0, 3'd5, 1'b1);
    // retransmit even though already acked
    send_req(REQ_TIMEOUT, '0, 3'd5, 1'b1);
    send_req(REQ_ACK, '0, 3'd4, 1'b1);
  endtask

  task automatic test_idle_request();
    send_req(REQ_NONE, '1, 3'd7, 1'b1);
    send_req(REQ_NONE, '0, 3'd0, 1'b0);
  endtask

  task automatic test_drain_pause();
    send_req(REQ_SEND, {$urandom, $urandom}, 3'd0, 1'b0);
    wait_all_results();
    send_req(REQ_TIMEOUT, '0, win_seq[0], 1'b1);
  endtask

  task automatic test_random_traffic(input int n_items);
    int done;
    int roll;
    logic [1:0]       rt;
    logic [PAY_W-1:0] pay;
    logic [SEQ_W-1:0] sq;
    logic             intact;
    done = 0;
    while (done < n_items) begin
      // switch at random between bursts of back-to-back requests and idling bursts
      if (done % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      roll   = $urandom_range(0, 99);
      pay    = {$urandom, $urandom};
      sq     = SEQ_W'($urandom_range(0, SEQ_SPACE - 1));
      intact = 1'b1;
      if (roll < 90 && win_count == 0) begin
        rt = REQ_SEND;
      end else if (roll < 40 && win_count < HALF) begin
        rt = REQ_SEND;
      end else if (roll < 75) begin
        rt     = REQ_ACK;
        sq     = win_seq[$urandom_range(0, win_count - 1)];
        intact = ($urandom_range(0, 9) != 0);
      end else if (roll < 90) begin
        rt     = REQ_TIMEOUT;
        sq     = win_seq[$urandom_range(0, win_count - 1)];
        intact = 1'($urandom_range(0, 1));
      end else begin
        rt     = 2'($urandom_range(0, 3));
        intact = 1'($urandom_range(0, 1));
      end
      send_req(rt, pay, sq, intact);
      if (rt != REQ_NONE) done++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = REQ_NONE;
    in_payload    = '0;
    in_seq_num    = '0;
    in_ack_intact = 1'b0;
    errors = 0; cycle_count = 0; n_checked = 0; n_sends = 0; n_refused = 0;
    n_acks = 0; n_timeouts = 0; n_slides = 0; no_idle = 1'b0;
    for (int i = 0; i < HALF; i++) begin
      win_seq[i]   = '0;
      win_pay[i]   = '0;
      win_acked[i] = 1'b0;
    end
    win_count = 0;
    win_next  = '0;
    win_base  = '0;
    win_full  = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_send_extremes();
    test_full_window();
    test_ack_cases();
    test_timeouts();
    test_idle_request();
    test_random_traffic(800);
    test_drain_pause();
    test_random_traffic(750);

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d sends (%0d refused on a full window), %0d acks, %0d timeouts",
             n_sends, n_refused, n_acks, n_timeouts);
    $display("Checked %0d results, window slid %0d times", n_checked, n_slides);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending_results.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
